// ===== design/sdtq_pkg.sv =====
package sdtq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int TIME_WIDTH_DEF  = 64;
  localparam int OWNER_WIDTH_DEF = 8;
  localparam int MAX_RESULTS     = 16;

  localparam int TIME_FIELD_W  = 64;
  localparam int OWNER_FIELD_W = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_EXPIRED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  // Broadcast command to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage

// ===== design/sorted_deadline_timer_queue.sv =====
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_op, in_time_value, in_owner
// out      out_valid / out_ready    out_owner_out, out_status, out_last
//
// An insert is accepted in S_IDLE; then, in S_INS, every cell compares the key
// against its entry and the chain shifts open in one step.
// A tick is accepted in S_IDLE; S_TICK then gives one beat per cycle while out_ready
// allows it, set by the head cell popping into the output register.
// Synchronous reset empties the chain by clearing its valid bits; entry data is not cleared.
// A stalled out_ready holds the chain; a new item is taken while a result waits.
module sorted_deadline_timer_queue #(
  parameter int DEPTH       = sdtq_pkg::DEPTH_DEF,
  parameter int TIME_WIDTH  = sdtq_pkg::TIME_WIDTH_DEF,
  parameter int OWNER_WIDTH = sdtq_pkg::OWNER_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [sdtq_pkg::TIME_FIELD_W-1:0]  in_time_value,
  input  logic [sdtq_pkg::OWNER_FIELD_W-1:0] in_owner,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sdtq_pkg::OWNER_FIELD_W-1:0] out_owner_out,
  output logic [1:0]                         out_status,
  output logic                               out_last
);
  import sdtq_pkg::*;

  localparam int OWNER_PAD = OWNER_WIDTH + OWNER_FIELD_W;
  localparam int CNT_W     = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_TICK = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0]  key_r;
  logic [OWNER_WIDTH-1:0] kown_r;
  logic [OWNER_PAD-1:0]   in_own_pad, out_own_pad;

  logic                   out_valid_r, out_valid_nxt;
  logic [OWNER_WIDTH-1:0] out_own_r, out_own_nxt;
  status_t                status_r, status_nxt;
  logic                   last_r, last_nxt;

  cell_cmd_t              cmd;
  logic                   in_acc, can_load, full, due0, due1;

  logic [DEPTH-1:0]       cell_valid, cell_gt;
  logic [TIME_WIDTH-1:0]  cell_tstamp [DEPTH];
  logic [OWNER_WIDTH-1:0] cell_owner  [DEPTH];

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_own_pad = OWNER_PAD'(in_owner);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= in_time_value[TIME_WIDTH-1:0];
      kown_r <= in_own_pad[OWNER_WIDTH-1:0];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   pv, pg, nv;
    logic [TIME_WIDTH-1:0]  pt, nt;
    logic [OWNER_WIDTH-1:0] po, no;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pg = 1'b0;
      assign pt = '0;
      assign po = '0;
    end else begin : g_body
      assign pv = cell_valid[i-1];
      assign pg = cell_gt[i-1];
      assign pt = cell_tstamp[i-1];
      assign po = cell_owner[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign nt = '0;
      assign no = '0;
    end else begin : g_mid
      assign nv = cell_valid[i+1];
      assign nt = cell_tstamp[i+1];
      assign no = cell_owner[i+1];
    end

    sdtq_cell #(
      .TIME_WIDTH  (TIME_WIDTH),
      .OWNER_WIDTH (OWNER_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .key         (key_r),
      .key_owner   (kown_r),
      .prev_valid  (pv),
      .prev_gt     (pg),
      .prev_tstamp (pt),
      .prev_owner  (po),
      .next_valid  (nv),
      .next_tstamp (nt),
      .next_owner  (no),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i]),
      .tstamp      (cell_tstamp[i]),
      .owner       (cell_owner[i])
    );
  end

  assign full     = cell_valid[DEPTH-1];
  assign due0     = cell_valid[0] && !cell_gt[0];
  assign due1     = cell_valid[1] && !cell_gt[1];
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_own_nxt   = out_own_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (op_t'(in_op) == OP_TICK) ? S_TICK : S_INS;
        end
      end
      S_INS: begin
        if (can_load) begin
          cmd.ins       = !full;
          out_valid_nxt = 1'b1;
          out_own_nxt   = kown_r;
          status_nxt    = full ? ST_REJECTED : ST_INSERTED;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK: begin
        if (can_load) begin
          if (due0) begin
            cmd.pop       = 1'b1;
            out_valid_nxt = 1'b1;
            out_own_nxt   = cell_owner[0];
            status_nxt    = ST_EXPIRED;
            last_nxt      = !due1 || (cnt_r == CNT_W'(MAX_RESULTS - 1));
            if (last_nxt) begin
              cnt_nxt   = '0;
              state_nxt = S_IDLE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            // nothing due: drop the tick without a beat
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_own_r <= out_own_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
  end

  assign out_own_pad   = OWNER_PAD'(out_own_r);
  assign out_valid     = out_valid_r;
  assign out_owner_out = out_own_pad[OWNER_FIELD_W-1:0];
  assign out_status    = status_r;
  assign out_last      = last_r;

  // Valid cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("valid cells not contiguous from head");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
    else $error("insert did not add exactly one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> $countones(cell_valid) + 1 == $past($countones(cell_valid)))
    else $error("expiry did not remove exactly one entry");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_TICK |-> cnt_r == '0)
    else $error("expiry count left over outside a tick");

endmodule

// ===== design/sdtq_cell.sv =====
module sdtq_cell #(
  parameter int TIME_WIDTH  = sdtq_pkg::TIME_WIDTH_DEF,
  parameter int OWNER_WIDTH = sdtq_pkg::OWNER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sdtq_pkg::cell_cmd_t    cmd,
  input  logic [TIME_WIDTH-1:0]  key,
  input  logic [OWNER_WIDTH-1:0] key_owner,
  input  logic                   prev_valid,
  input  logic                   prev_gt,
  input  logic [TIME_WIDTH-1:0]  prev_tstamp,
  input  logic [OWNER_WIDTH-1:0] prev_owner,
  input  logic                   next_valid,
  input  logic [TIME_WIDTH-1:0]  next_tstamp,
  input  logic [OWNER_WIDTH-1:0] next_owner,
  output logic                   valid,
  output logic                   gt,
  output logic [TIME_WIDTH-1:0]  tstamp,
  output logic [OWNER_WIDTH-1:0] owner
);
  import sdtq_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [TIME_WIDTH-1:0]  tstamp_r, tstamp_nxt;
  logic [OWNER_WIDTH-1:0] owner_r, owner_nxt;
  logic                   take_new;

  // Key strictly below this entry: a new entry lands in front of it.
  assign gt = valid_r && (key < tstamp_r);

  assign take_new = !prev_gt && prev_valid && (gt || !valid_r);

  always_comb begin
    priority if (cmd.pop) begin
      // advance toward the head
      valid_nxt  = next_valid;
      tstamp_nxt = next_tstamp;
      owner_nxt  = next_owner;
    end else if (cmd.ins && prev_gt) begin
      valid_nxt  = 1'b1;
      tstamp_nxt = prev_tstamp;
      owner_nxt  = prev_owner;
    end else if (cmd.ins && take_new) begin
      valid_nxt  = 1'b1;
      tstamp_nxt = key;
      owner_nxt  = key_owner;
    end else begin
      // hold
      valid_nxt  = valid_r;
      tstamp_nxt = tstamp_r;
      owner_nxt  = owner_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tstamp_r <= tstamp_nxt;
    owner_r  <= owner_nxt;
  end

  assign valid  = valid_r;
  assign tstamp = tstamp_r;
  assign owner  = owner_r;

endmodule
